// File: rtl/sedge_pkg.sv
// Shared types and constants for the silhouette edge extractor.
// Used by the channel interfaces, the dot-product unit, the top level and the checker.
// No dependencies.
package sedge_pkg;

    // Field widths of the channels.
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 16;
    localparam int NORM_W   = 16;
    localparam int POS_W    = 24;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int REG_W    = 2;

    // Arithmetic widths of the facing test.
    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = NORM_W + DIFF_W;
    localparam int ACC_W  = PROD_W + 2;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_TRI   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_W-1:0] REG_POSITIONAL = 2'd0;
    localparam logic [REG_W-1:0] REG_LIGHT_X    = 2'd1;
    localparam logic [REG_W-1:0] REG_LIGHT_Y    = 2'd2;
    localparam logic [REG_W-1:0] REG_LIGHT_Z    = 2'd3;

    // Reset value of the light z component (-1.0).
    localparam logic [POS_W-1:0] LIGHT_Z_RESET = 24'hFFFF00;

    // Three-component vectors, component x at index 0.
    typedef logic [2:0][NORM_W-1:0] norm3_t;
    typedef logic [2:0][POS_W-1:0]  pos3_t;

    // Status reported by the dot-product unit.
    typedef struct packed {
        logic done;
        logic facing;
    } dot_stat_t;

endpackage

// File: rtl/sedge_if.sv
// Valid/ready channel interfaces of the silhouette edge extractor.
// Depends on sedge_pkg for the field widths.

// Input items: triangles, read and clear commands.
interface sedge_in_if;
    logic                              valid;
    logic                              ready;
    logic [sedge_pkg::CMD_W-1:0]       command;
    logic [sedge_pkg::VERTEX_W-1:0]    vertex_first;
    logic [sedge_pkg::VERTEX_W-1:0]    vertex_second;
    logic [sedge_pkg::VERTEX_W-1:0]    vertex_third;
    logic signed [sedge_pkg::NORM_W-1:0] normal_x;
    logic signed [sedge_pkg::NORM_W-1:0] normal_y;
    logic signed [sedge_pkg::NORM_W-1:0] normal_z;
    logic signed [sedge_pkg::POS_W-1:0]  center_x;
    logic signed [sedge_pkg::POS_W-1:0]  center_y;
    logic signed [sedge_pkg::POS_W-1:0]  center_z;
    logic [sedge_pkg::INDEX_W-1:0]     edge_index;

    modport source (
        output valid, command, vertex_first, vertex_second, vertex_third,
               normal_x, normal_y, normal_z, center_x, center_y, center_z, edge_index,
        input  ready
    );
    modport sink (
        input  valid, command, vertex_first, vertex_second, vertex_third,
               normal_x, normal_y, normal_z, center_x, center_y, center_z, edge_index,
        output ready
    );
endinterface

// Result items, one per input item.
interface sedge_out_if;
    logic                            valid;
    logic                            ready;
    logic                            facing;
    logic [sedge_pkg::COUNT_W-1:0]   edge_count;
    logic [sedge_pkg::VERTEX_W-1:0]  point_a;
    logic [sedge_pkg::VERTEX_W-1:0]  point_b;
    logic                            entry_valid;
    logic                            overflow;

    modport source (
        output valid, facing, edge_count, point_a, point_b, entry_valid, overflow,
        input  ready
    );
    modport sink (
        input  valid, facing, edge_count, point_a, point_b, entry_valid, overflow,
        output ready
    );
endinterface

// Configuration register writes.
interface sedge_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sedge_pkg::REG_W-1:0]   index;
    logic [sedge_pkg::POS_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/silhouette_edge_extractor.sv
// Silhouette edge extractor. A triangle item is tested against the light with a
// sequential dot product (four phases, a multiply in each of the first three), and a facing
// triangle then toggles each of its edges in an unordered edge set held in one
// single-port-read memory. Each toggle scans the set one entry per cycle on the memory read
// port. One item is in work at a time; its result sits in an output register, and the next
// item is taken while that result still waits. The edge memory needs no clearing after reset.
// Depends on sedge_pkg, the channel interfaces and sedge_dot.
module silhouette_edge_extractor #(
    parameter int EDGE_CAPACITY = 1024,
    parameter int INDEX_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sedge_in_if.sink     item,
    sedge_out_if.source  result,
    sedge_cfg_if.sink    cfg
);

    // Stored vertex width, address width and count width.
    localparam int SW = (INDEX_BITS < sedge_pkg::VERTEX_W) ? INDEX_BITS : sedge_pkg::VERTEX_W;
    localparam int AW = $clog2(EDGE_CAPACITY);
    localparam int CW = $clog2(EDGE_CAPACITY + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DOT  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // Configuration registers.
    logic                           positional_reg;
    logic [sedge_pkg::POS_W-1:0]    light_x_reg;
    logic [sedge_pkg::POS_W-1:0]    light_y_reg;
    logic [sedge_pkg::POS_W-1:0]    light_z_reg;

    // Captured item.
    logic [SW-1:0]                  v0_reg;
    logic [SW-1:0]                  v1_reg;
    logic [SW-1:0]                  v2_reg;
    sedge_pkg::norm3_t              normal_reg;
    sedge_pkg::pos3_t               center_reg;

    // Sequencer state.
    logic [2:0]  state_reg,    state_next;
    logic [CW-1:0] held_reg,   held_next;
    logic [CW-1:0] issue_reg,  issue_next;
    logic        rd_v_reg,     rd_v_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] match_idx_reg, match_idx_next;
    logic [1:0]  edge_sel_reg, edge_sel_next;

    // Result under construction.
    logic        res_facing_reg, res_facing_next;
    logic        res_ovf_reg,    res_ovf_next;
    logic        res_valid_reg,  res_valid_next;
    logic [sedge_pkg::VERTEX_W-1:0] res_pa_reg, res_pa_next;
    logic [sedge_pkg::VERTEX_W-1:0] res_pb_reg, res_pb_next;

    // Output register.
    logic        out_valid_reg;
    logic        out_facing_reg;
    logic        out_ovf_reg;
    logic        out_entry_reg;
    logic [sedge_pkg::COUNT_W-1:0]  out_count_reg;
    logic [sedge_pkg::VERTEX_W-1:0] out_pa_reg;
    logic [sedge_pkg::VERTEX_W-1:0] out_pb_reg;

    // Edge memory and its ports.
    logic [2*SW-1:0] edge_mem [EDGE_CAPACITY];
    logic [2*SW-1:0] mem_rdata_reg;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [2*SW-1:0] mem_wdata;

    logic                 item_xfer;
    logic                 out_load;
    logic                 dot_start;
    sedge_pkg::dot_stat_t dot_stat;
    logic [SW-1:0]        edge_a;
    logic [SW-1:0]        edge_b;
    logic [SW-1:0]        stored_a;
    logic [SW-1:0]        stored_b;
    logic                 hit;
    logic                 edge_done;
    logic                 read_ok;
    logic [31:0]          count_wide;

    assign item_xfer = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    // Facing test unit.
    sedge_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dot_start),
        .positional (positional_reg),
        .normal     (normal_reg),
        .center     (center_reg),
        .light      ({light_z_reg, light_y_reg, light_x_reg}),
        .stat       (dot_stat)
    );

    // Edge under toggle and the compare against the entry just read.
    always_comb
    begin
        case (edge_sel_reg)
            2'd0:
            begin
                edge_a = v0_reg;
                edge_b = v1_reg;
            end
            2'd1:
            begin
                edge_a = v1_reg;
                edge_b = v2_reg;
            end
            default:
            begin
                edge_a = v2_reg;
                edge_b = v0_reg;
            end
        endcase
        stored_a = mem_rdata_reg[2*SW-1:SW];
        stored_b = mem_rdata_reg[SW-1:0];
        hit = rd_v_reg && (((stored_a == edge_a) && (stored_b == edge_b)) ||
                           ((stored_a == edge_b) && (stored_b == edge_a)));
        read_ok = (32'(item.edge_index) < 32'(held_reg));
    end

    // Sequencer: reads, clears, and for a triangle scan, remove by moving the last entry, or append.
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        issue_next      = issue_reg;
        rd_v_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;
        match_idx_next  = match_idx_reg;
        edge_sel_next   = edge_sel_reg;
        res_facing_next = res_facing_reg;
        res_ovf_next    = res_ovf_reg;
        res_valid_next  = res_valid_reg;
        res_pa_next     = res_pa_reg;
        res_pb_next     = res_pb_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        dot_start       = 1'b0;
        edge_done       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    res_facing_next = 1'b0;
                    res_ovf_next    = 1'b0;
                    res_valid_next  = 1'b0;
                    res_pa_next     = '0;
                    res_pb_next     = '0;
                    case (item.command)
                        sedge_pkg::CMD_TRI:
                        begin
                            dot_start  = 1'b1;
                            state_next = S_DOT;
                        end
                        sedge_pkg::CMD_READ:
                        begin
                            res_valid_next = read_ok;
                            mem_re         = read_ok;
                            mem_raddr      = AW'(item.edge_index);
                            state_next     = S_READ;
                        end
                        sedge_pkg::CMD_CLEAR:
                        begin
                            held_next  = '0;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DOT:
            begin
                if (dot_stat.done)
                begin
                    res_facing_next = dot_stat.facing;
                    edge_sel_next   = 2'd0;
                    issue_next      = '0;
                    state_next      = dot_stat.facing ? S_SCAN : S_FIN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // Fetch the last entry to fill the slot of the match.
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(held_reg - CW'(1));
                    match_idx_next = rd_idx_reg;
                    state_next     = S_MOVE;
                end
                else if (issue_reg < held_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = AW'(issue_reg);
                    rd_v_next   = 1'b1;
                    rd_idx_next = AW'(issue_reg);
                    issue_next  = issue_reg + CW'(1);
                end
                else if (!rd_v_reg)
                begin
                    // No match anywhere: append, or drop when the set is full.
                    if (32'(held_reg) < EDGE_CAPACITY)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(held_reg);
                        mem_wdata = {edge_a, edge_b};
                        held_next = held_reg + CW'(1);
                    end
                    else
                    begin
                        res_ovf_next = 1'b1;
                    end
                    edge_done = 1'b1;
                end
            end
            S_MOVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = match_idx_reg;
                mem_wdata = mem_rdata_reg;
                held_next = held_reg - CW'(1);
                edge_done = 1'b1;
            end
            S_READ:
            begin
                if (res_valid_reg)
                begin
                    res_pa_next = sedge_pkg::VERTEX_W'(stored_a);
                    res_pb_next = sedge_pkg::VERTEX_W'(stored_b);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Move on to the next edge of the triangle, or finish after the third.
        if (edge_done)
        begin
            issue_next = '0;
            if (edge_sel_reg == 2'd2)
                state_next = S_FIN;
            else
            begin
                edge_sel_next = edge_sel_reg + 2'd1;
                state_next    = S_SCAN;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            rd_v_reg  <= rd_v_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            positional_reg <= 1'b0;
            light_x_reg    <= '0;
            light_y_reg    <= '0;
            light_z_reg    <= sedge_pkg::LIGHT_Z_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sedge_pkg::REG_POSITIONAL: positional_reg <= cfg.data[0];
                sedge_pkg::REG_LIGHT_X:    light_x_reg    <= cfg.data;
                sedge_pkg::REG_LIGHT_Y:    light_y_reg    <= cfg.data;
                sedge_pkg::REG_LIGHT_Z:    light_z_reg    <= cfg.data;
                default:                   light_x_reg    <= light_x_reg;
            endcase
        end
    end

    // Item capture, scan bookkeeping and result registers.
    assign count_wide = 32'(held_reg);

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            v0_reg     <= item.vertex_first[SW-1:0];
            v1_reg     <= item.vertex_second[SW-1:0];
            v2_reg     <= item.vertex_third[SW-1:0];
            normal_reg <= {item.normal_z, item.normal_y, item.normal_x};
            center_reg <= {item.center_z, item.center_y, item.center_x};
        end
        issue_reg      <= issue_next;
        rd_idx_reg     <= rd_idx_next;
        match_idx_reg  <= match_idx_next;
        edge_sel_reg   <= edge_sel_next;
        res_facing_reg <= res_facing_next;
        res_ovf_reg    <= res_ovf_next;
        res_valid_reg  <= res_valid_next;
        res_pa_reg     <= res_pa_next;
        res_pb_reg     <= res_pb_next;
        if (out_load)
        begin
            out_facing_reg <= res_facing_reg;
            out_ovf_reg    <= res_ovf_reg;
            out_entry_reg  <= res_valid_reg;
            out_pa_reg     <= res_pa_reg;
            out_pb_reg     <= res_pb_reg;
            out_count_reg  <= count_wide[sedge_pkg::COUNT_W-1:0];
        end
    end

    // Edge memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            edge_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= edge_mem[mem_raddr];
    end

    assign result.valid       = out_valid_reg;
    assign result.facing      = out_facing_reg;
    assign result.edge_count  = out_count_reg;
    assign result.point_a     = out_pa_reg;
    assign result.point_b     = out_pb_reg;
    assign result.entry_valid = out_entry_reg;
    assign result.overflow    = out_ovf_reg;

endmodule

// File: rtl/sedge_dot.sv
// Sequential facing test: one signed multiply per cycle over the three components.
// Depends on sedge_pkg for widths and the status struct.
module sedge_dot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 positional,
    input  sedge_pkg::norm3_t    normal,
    input  sedge_pkg::pos3_t     center,
    input  sedge_pkg::pos3_t     light,
    output sedge_pkg::dot_stat_t stat
);

    logic [1:0]                          phase_reg;
    logic                                busy_reg;
    logic signed [sedge_pkg::PROD_W-1:0] prod_reg;
    logic signed [sedge_pkg::ACC_W-1:0]  acc_reg;
    sedge_pkg::dot_stat_t                stat_reg;

    logic signed [sedge_pkg::NORM_W-1:0] n_sel;
    logic signed [sedge_pkg::POS_W-1:0]  c_sel;
    logic signed [sedge_pkg::POS_W-1:0]  l_sel;
    logic signed [sedge_pkg::DIFF_W-1:0] d_sel;
    logic signed [sedge_pkg::PROD_W-1:0] prod;
    logic signed [sedge_pkg::ACC_W-1:0]  acc_sum;

    // Pick the component of this phase and form its light term.
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                n_sel = $signed(normal[0]);
                c_sel = $signed(center[0]);
                l_sel = $signed(light[0]);
            end
            2'd1:
            begin
                n_sel = $signed(normal[1]);
                c_sel = $signed(center[1]);
                l_sel = $signed(light[1]);
            end
            default:
            begin
                n_sel = $signed(normal[2]);
                c_sel = $signed(center[2]);
                l_sel = $signed(light[2]);
            end
        endcase
        if (positional)
            d_sel = sedge_pkg::DIFF_W'(c_sel) - sedge_pkg::DIFF_W'(l_sel);
        else
            d_sel = sedge_pkg::DIFF_W'(l_sel);
        prod    = n_sel * d_sel;
        acc_sum = acc_reg + sedge_pkg::ACC_W'(prod_reg);
    end

    // Phase counter and completion status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            stat_reg  <= '0;
        end
        else
        begin
            stat_reg.done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg        <= 1'b0;
                    stat_reg.done   <= 1'b1;
                    stat_reg.facing <= ~acc_sum[sedge_pkg::ACC_W-1];
                end
            end
        end
    end

    // Product register and accumulator; the accumulator adds the registered product of the multiply.
    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= '0;
        else if (busy_reg)
        begin
            if (phase_reg != 2'd3)
                prod_reg <= prod;
            if (phase_reg != 2'd0)
                acc_reg <= acc_sum;
        end
    end

    assign stat = stat_reg;

endmodule

// File: rtl/sedge_checker.sv
// Port-level checks for the silhouette edge extractor, attached by bind.
// Depends on sedge_pkg and the top level silhouette_edge_extractor.
module sedge_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic                          facing,
    input logic                          overflow,
    input logic                          entry_valid,
    input logic [sedge_pkg::COUNT_W-1:0] edge_count
);

    // A result waiting for transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
    else $error("result dropped before transfer");

    // A waiting result keeps its edge count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(edge_count))
    else $error("edge count changed while result stalled");

    // One item at a time: no item is taken in the cycle right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item in work");

    // Only a facing triangle can drop an edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |-> facing)
    else $error("overflow without facing triangle");

    // A read result carries neither facing nor overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && entry_valid |-> !facing && !overflow)
    else $error("read result mixed with triangle flags");

endmodule

bind silhouette_edge_extractor sedge_checker u_sedge_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .facing       (result.facing),
    .overflow     (result.overflow),
    .entry_valid  (result.entry_valid),
    .edge_count   (result.edge_count)
);

// File: verif/tb_top.sv
// Self-checking testbench for silhouette_edge_extractor: drives triangle, read and clear
// items under random idling and predicts each result from its own facing test and edge set.
// Depends on sedge_pkg, the channel interfaces in sedge_if.sv and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_SLOTS = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int REPORT_MAX = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [sedge_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [sedge_pkg::CMD_W-1:0]         command;
        logic [sedge_pkg::VERTEX_W-1:0]      vertex_first;
        logic [sedge_pkg::VERTEX_W-1:0]      vertex_second;
        logic [sedge_pkg::VERTEX_W-1:0]      vertex_third;
        logic signed [sedge_pkg::NORM_W-1:0] normal_x;
        logic signed [sedge_pkg::NORM_W-1:0] normal_y;
        logic signed [sedge_pkg::NORM_W-1:0] normal_z;
        logic signed [sedge_pkg::POS_W-1:0]  center_x;
        logic signed [sedge_pkg::POS_W-1:0]  center_y;
        logic signed [sedge_pkg::POS_W-1:0]  center_z;
        logic [sedge_pkg::INDEX_W-1:0]       edge_index;
    } edge_item_t;

    typedef struct {
        logic                            facing;
        logic [sedge_pkg::COUNT_W-1:0]   edge_count;
        logic [sedge_pkg::VERTEX_W-1:0]  point_a;
        logic [sedge_pkg::VERTEX_W-1:0]  point_b;
        logic                            entry_valid;
        logic                            overflow;
    } edge_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sedge_in_if  item_ch();
    sedge_out_if result_ch();
    sedge_cfg_if cfg_ch();

    silhouette_edge_extractor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Our own copy of the light setting and of the edge set.
    logic                               light_positional = 1'b0;
    logic signed [sedge_pkg::POS_W-1:0] light_x = '0;
    logic signed [sedge_pkg::POS_W-1:0] light_y = '0;
    logic signed [sedge_pkg::POS_W-1:0] light_z = sedge_pkg::LIGHT_Z_RESET;
    logic [sedge_pkg::VERTEX_W-1:0]     held_a [EDGE_SLOTS];
    logic [sedge_pkg::VERTEX_W-1:0]     held_b [EDGE_SLOTS];
    int                                 held_count = 0;

    edge_report_t reports_due[$];
    int           send_idle_pct = 0;
    int           take_idle_pct = 0;
    int           failures = 0;

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s", what);
    endfunction

    // Toggles one edge in the predicted set; returns 1 when an append is dropped.
    function automatic logic toggle_edge(input logic [sedge_pkg::VERTEX_W-1:0] a,
                                         input logic [sedge_pkg::VERTEX_W-1:0] b);
        int i;
        for (i = 0; i < held_count; i++)
        begin
            if ((held_a[i] == a && held_b[i] == b) || (held_a[i] == b && held_b[i] == a))
            begin
                held_a[i] = held_a[held_count-1];
                held_b[i] = held_b[held_count-1];
                held_count--;
                return 1'b0;
            end
        end
        if (held_count >= EDGE_SLOTS)
            return 1'b1;
        held_a[held_count] = a;
        held_b[held_count] = b;
        held_count++;
        return 1'b0;
    endfunction

    // Works out the report for one item and advances the predicted edge set.
    function automatic edge_report_t silhouette_outcome(input edge_item_t it);
        edge_report_t r;
        longint       dx;
        longint       dy;
        longint       dz;
        longint       dot;
        logic         dropped;
        r = '{default: '0};
        if (it.command == sedge_pkg::CMD_TRI)
        begin
            dx = longint'(light_x);
            dy = longint'(light_y);
            dz = longint'(light_z);
            // A positional light points from the light to the triangle center.
            if (light_positional)
            begin
                dx = longint'(it.center_x) - dx;
                dy = longint'(it.center_y) - dy;
                dz = longint'(it.center_z) - dz;
            end
            dot = longint'(it.normal_x) * dx + longint'(it.normal_y) * dy
                + longint'(it.normal_z) * dz;
            if (dot >= 0)
            begin
                r.facing = 1'b1;
                dropped = toggle_edge(it.vertex_first, it.vertex_second);
                dropped = toggle_edge(it.vertex_second, it.vertex_third) | dropped;
                dropped = toggle_edge(it.vertex_third, it.vertex_first) | dropped;
                r.overflow = dropped;
            end
        end
        else if (it.command == sedge_pkg::CMD_READ)
        begin
            if (it.edge_index < held_count)
            begin
                r.entry_valid = 1'b1;
                r.point_a = held_a[it.edge_index];
                r.point_b = held_b[it.edge_index];
            end
        end
        else if (it.command == sedge_pkg::CMD_CLEAR)
        begin
            held_count = 0;
        end
        r.edge_count = held_count[sedge_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // An item with every field random; the builders below override what matters.
    function automatic edge_item_t random_item();
        edge_item_t  it;
        logic [31:0] w;
        w = $urandom();
        it.command = w[sedge_pkg::CMD_W-1:0];
        it.edge_index = w[sedge_pkg::INDEX_W+7:8];
        w = $urandom();
        it.vertex_first = w[15:0];
        it.vertex_second = w[31:16];
        w = $urandom();
        it.vertex_third = w[15:0];
        it.normal_x = w[31:16];
        w = $urandom();
        it.normal_y = w[15:0];
        it.normal_z = w[31:16];
        w = $urandom();
        it.center_x = w[sedge_pkg::POS_W-1:0];
        w = $urandom();
        it.center_y = w[sedge_pkg::POS_W-1:0];
        w = $urandom();
        it.center_z = w[sedge_pkg::POS_W-1:0];
        return it;
    endfunction

    function automatic edge_item_t tri_item(input logic [sedge_pkg::VERTEX_W-1:0] v0,
                                            input logic [sedge_pkg::VERTEX_W-1:0] v1,
                                            input logic [sedge_pkg::VERTEX_W-1:0] v2,
                                            input logic [sedge_pkg::NORM_W-1:0] nx,
                                            input logic [sedge_pkg::NORM_W-1:0] ny,
                                            input logic [sedge_pkg::NORM_W-1:0] nz);
        edge_item_t it;
        it = random_item();
        it.command = sedge_pkg::CMD_TRI;
        it.vertex_first = v0;
        it.vertex_second = v1;
        it.vertex_third = v2;
        it.normal_x = nx;
        it.normal_y = ny;
        it.normal_z = nz;
        return it;
    endfunction

    function automatic edge_item_t ctl_item(input logic [sedge_pkg::CMD_W-1:0] cmd,
                                            input logic [sedge_pkg::INDEX_W-1:0] idx);
        edge_item_t it;
        it = random_item();
        it.command = cmd;
        it.edge_index = idx;
        return it;
    endfunction

    // Light component for random settings, with the extremes weighted in.
    function automatic logic [sedge_pkg::POS_W-1:0] pick_coord();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            3: return w[sedge_pkg::POS_W-1:0] - 24'd1024 + {14'd0, w[9:0]}
                      - w[sedge_pkg::POS_W-1:0];
            default: return w[sedge_pkg::POS_W-1:0];
        endcase
    endfunction

    // Sends one item, idling first at random; the prediction is made at the transfer.
    task automatic send_item(input edge_item_t it);
        logic took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= it.command;
        item_ch.vertex_first <= it.vertex_first;
        item_ch.vertex_second <= it.vertex_second;
        item_ch.vertex_third <= it.vertex_third;
        item_ch.normal_x <= it.normal_x;
        item_ch.normal_y <= it.normal_y;
        item_ch.normal_z <= it.normal_z;
        item_ch.center_x <= it.center_x;
        item_ch.center_y <= it.center_y;
        item_ch.center_z <= it.center_z;
        item_ch.edge_index <= it.edge_index;
        do
        begin
            @(negedge clk);
            took = item_ch.ready;
            @(posedge clk);
        end
        while (took !== 1'b1);
        reports_due.push_back(silhouette_outcome(it));
    endtask

    // Writes all four light registers; only called while the block is idle.
    task automatic set_light(input logic positional,
                             input logic [sedge_pkg::POS_W-1:0] lx,
                             input logic [sedge_pkg::POS_W-1:0] ly,
                             input logic [sedge_pkg::POS_W-1:0] lz);
        logic [sedge_pkg::REG_W-1:0] regs [4] = '{sedge_pkg::REG_POSITIONAL,
            sedge_pkg::REG_LIGHT_X, sedge_pkg::REG_LIGHT_Y, sedge_pkg::REG_LIGHT_Z};
        logic [sedge_pkg::POS_W-1:0] values [4];
        logic                        took;
        int                          r;
        values[0] = {{(sedge_pkg::POS_W-1){1'b0}}, positional};
        values[1] = lx;
        values[2] = ly;
        values[3] = lz;
        for (r = 0; r < 4; r++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[r];
            cfg_ch.data <= values[r];
            do
            begin
                @(negedge clk);
                took = cfg_ch.ready;
                @(posedge clk);
            end
            while (took !== 1'b1);
            case (regs[r])
                sedge_pkg::REG_POSITIONAL: light_positional = values[r][0];
                sedge_pkg::REG_LIGHT_X:    light_x = values[r];
                sedge_pkg::REG_LIGHT_Y:    light_y = values[r];
                sedge_pkg::REG_LIGHT_Z:    light_z = values[r];
                default:                   ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops sending and waits until every predicted report has arrived.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Extremes of the fields, every command and the edge set corner cases
    // under the reset light (directional, pointing down z).
    task automatic test_directed_edges();
        int i;
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd0));
        send_item(tri_item(16'h0000, 16'hFFFF, 16'h5A5A, 16'h7FFF, 16'h8000, 16'h8000));
        for (i = 0; i < 3; i++)
            send_item(ctl_item(sedge_pkg::CMD_READ, i[sedge_pkg::INDEX_W-1:0]));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'h3FF));
        // Back-facing copy leaves the set alone.
        send_item(tri_item(16'h0000, 16'hFFFF, 16'h5A5A, 16'h0000, 16'h0000, 16'h7FFF));
        // Zero dot product still faces; reversed winding removes every edge of the first triangle.
        send_item(tri_item(16'h5A5A, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000));
        // Degenerate edge from a repeated vertex.
        send_item(tri_item(16'h0007, 16'h0007, 16'h0009, 16'h0000, 16'h0000, 16'hFFFF));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd0));
        send_item(ctl_item(CMD_UNUSED, 10'd0));
        send_item(ctl_item(sedge_pkg::CMD_CLEAR, 10'd0));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd0));
        // Shared edge removed from the middle, with the last entry moved in.
        send_item(tri_item(16'd1, 16'd2, 16'd3, 16'h1234, 16'h8765, 16'hFFFB));
        send_item(tri_item(16'd3, 16'd4, 16'd1, 16'h0000, 16'h0000, 16'hFFFB));
        for (i = 0; i < 5; i++)
            send_item(ctl_item(sedge_pkg::CMD_READ, i[sedge_pkg::INDEX_W-1:0]));
        send_item(tri_item(16'd5, 16'd6, 16'd7, 16'h7FFF, 16'h8000, 16'h0001));
        wait_idle();
    endtask

    // Positional light with the light and the centers at their extremes.
    task automatic test_positional_light();
        edge_item_t it;
        set_light(1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        it = tri_item(16'd10, 16'd11, 16'd12, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        it.center_x = 24'h800000;
        it.center_y = 24'h7FFFFF;
        it.center_z = 24'h800000;
        send_item(it);
        it.normal_x = 16'h8000;
        it.normal_y = 16'h7FFF;
        it.normal_z = 16'h8000;
        send_item(it);
        // Center on the light: zero difference faces.
        it.center_x = 24'h7FFFFF;
        it.center_y = 24'h800000;
        it.center_z = 24'h7FFFFF;
        send_item(it);
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd0));
        wait_idle();
        set_light(1'b1, 24'h800000, 24'h7FFFFF, 24'h000000);
        it = tri_item(16'd20, 16'd21, 16'd22, 16'h8000, 16'h7FFF, 16'h8000);
        it.center_x = 24'h7FFFFF;
        it.center_y = 24'h800000;
        it.center_z = 24'h7FFFFF;
        send_item(it);
        it.normal_x = 16'h0000;
        it.normal_y = 16'h0000;
        it.normal_z = 16'h0000;
        send_item(it);
        it = tri_item(16'd20, 16'd22, 16'd23, 16'h7FFF, 16'h8000, 16'h0001);
        it.center_x = 24'h7FFFFF;
        it.center_y = 24'h800000;
        it.center_z = 24'h000000;
        send_item(it);
        send_item(ctl_item(sedge_pkg::CMD_CLEAR, 10'd0));
        wait_idle();
    endtask

    // Random light, then mostly triangles over a small vertex pool so that edges
    // meet again, with reads, clears, unused commands and noise mixed in.
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int take_pct);
        logic [sedge_pkg::VERTEX_W-1:0] pool [6];
        logic [31:0]                    w;
        edge_item_t                     it;
        int                             i;
        int                             pick;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        set_light(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
        for (i = 0; i < 6; i++)
        begin
            w = $urandom();
            pool[i] = w[sedge_pkg::VERTEX_W-1:0];
        end
        for (i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                it = random_item();
                it.command = sedge_pkg::CMD_TRI;
                it.vertex_first = pool[$urandom_range(5)];
                it.vertex_second = pool[$urandom_range(5)];
                it.vertex_third = pool[$urandom_range(5)];
            end
            else if (pick < 85)
            begin
                it = ctl_item(sedge_pkg::CMD_READ, 10'd0);
                w = $urandom_range(1023);
                if (held_count > 0 && $urandom_range(1) == 1)
                    w = $urandom_range(held_count - 1);
                it.edge_index = w[sedge_pkg::INDEX_W-1:0];
            end
            else if (pick < 90)
                it = ctl_item(sedge_pkg::CMD_CLEAR, 10'd0);
            else if (pick < 95)
                it = ctl_item(CMD_UNUSED, 10'd0);
            else
                it = random_item();
            send_item(it);
        end
        wait_idle();
    endtask

    // Grows the edge set with disjoint triangles, then drives removals from it,
    // re-appends and a back-facing triangle against it.
    task automatic test_grown_set();
        logic [31:0] w;
        int          vbase;
        int          vb;
        int          k;
        set_light(1'b0, 24'h000000, 24'h000000, 24'h800000);
        send_item(ctl_item(sedge_pkg::CMD_CLEAR, 10'd0));
        vbase = $urandom_range(64000);
        for (k = 0; k < 12; k++)
        begin
            vb = vbase + 3 * k;
            w = 32'd0 - $urandom_range(32768);
            send_item(tri_item(vb[15:0], vb[15:0] + 16'd1, vb[15:0] + 16'd2,
                               16'($urandom()), 16'($urandom()), w[15:0]));
        end
        send_item(tri_item(16'hFFFD, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd38));
        vb = vbase;
        send_item(tri_item(vb[15:0], vb[15:0] + 16'd1, vb[15:0] + 16'd2,
                           16'h0000, 16'h0000, 16'h8000));
        send_item(tri_item(vb[15:0] + 16'd2, vb[15:0] + 16'd1, vb[15:0],
                           16'h0000, 16'h0000, 16'h8000));
        send_item(tri_item(16'hFFFD, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        send_item(tri_item(16'h1111, 16'h2222, 16'h3333, 16'h0000, 16'h0000, 16'h0001));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'h3FF));
        send_item(ctl_item(sedge_pkg::CMD_CLEAR, 10'd0));
        send_item(ctl_item(sedge_pkg::CMD_READ, 10'd0));
        wait_idle();
    endtask

    // Result ready, with random stalls.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Each result transfer is checked against the oldest prediction. Sampling
    // happens at the falling edge, ahead of the rising edge that takes the transfer.
    always @(negedge clk)
    begin
        edge_report_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (reports_due.size() == 0)
                note_failure("result transfer with no report expected");
            else
            begin
                want = reports_due.pop_front();
                if (result_ch.facing !== want.facing
                    || result_ch.edge_count !== want.edge_count
                    || result_ch.point_a !== want.point_a
                    || result_ch.point_b !== want.point_b
                    || result_ch.entry_valid !== want.entry_valid
                    || result_ch.overflow !== want.overflow)
                    note_failure($sformatf({"report mismatch: expected facing=%0b count=%0d ",
                        "a=%h b=%h valid=%0b ovf=%0b, got facing=%0b count=%0d a=%h b=%h ",
                        "valid=%0b ovf=%0b"}, want.facing, want.edge_count, want.point_a,
                        want.point_b, want.entry_valid, want.overflow, result_ch.facing,
                        result_ch.edge_count, result_ch.point_a, result_ch.point_b,
                        result_ch.entry_valid, result_ch.overflow));
            end
        end
    end

    // Watchdog: ends the run when no channel has made a transfer for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("silhouette_edge_extractor verification failed");
        $finish;
    end

    // Test sequence.
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.command = sedge_pkg::CMD_TRI;
        item_ch.vertex_first = '0;
        item_ch.vertex_second = '0;
        item_ch.vertex_third = '0;
        item_ch.normal_x = '0;
        item_ch.normal_y = '0;
        item_ch.normal_z = '0;
        item_ch.center_x = '0;
        item_ch.center_y = '0;
        item_ch.center_z = '0;
        item_ch.edge_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = sedge_pkg::REG_POSITIONAL;
        cfg_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        take_idle_pct = 76;
        test_directed_edges();
        test_positional_light();
        test_random_traffic(50, 24, 76);
        test_random_traffic(50, 76, 24);
        test_random_traffic(40, 0, 0);
        test_grown_set();
        wait_idle();

        if (failures == 0 && reports_due.size() == 0)
            $display("silhouette_edge_extractor verification clean");
        else
            $display("silhouette_edge_extractor verification failed");
        $finish;
    end

endmodule
